### hw/rtl/oist_pkg.sv
package oist_pkg;

  localparam int DATA_W  = 32;
  localparam int INDEX_W = 6;
  localparam int COUNT_W = 7;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic load;        // latch the transaction, rewind the scan
    logic step;        // issue the next table read
    logic shift_wr;    // write the returned word one place lower
    logic goto_shift;  // rewind the pointer to just past the hit
    logic append;      // write value at the end, count up
    logic remove;      // count down
    logic rd_idx;      // read address comes from the index field
    logic finish;      // load result registers, pulse done
    logic found;
    logic changed;
    logic drop;
    logic rd;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] op;
    logic       hit;
    logic       scan_end;
    logic       full;
  } sts_t;

endpackage

### hw/rtl/oist_dp.sv
module oist_dp #(
  parameter int CAPACITY = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  oist_pkg::cmd_t                       cmd,
  output oist_pkg::sts_t                       sts,
  input  logic [1:0]                           opcode,
  input  logic signed [oist_pkg::DATA_W-1:0]   value,
  input  logic [oist_pkg::INDEX_W-1:0]         index,
  output logic                                 done,
  output logic                                 found,
  output logic                                 changed,
  output logic                                 full_drop,
  output logic signed [oist_pkg::DATA_W-1:0]   read_value,
  output logic                                 read_invalid,
  output logic [oist_pkg::COUNT_W-1:0]         count,
  output logic                                 empty_res
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > oist_pkg::INDEX_W) ? CW : oist_pkg::INDEX_W;

  logic [oist_pkg::DATA_W-1:0]  mem [CAPACITY];

  logic [1:0]                   op_q;
  logic [oist_pkg::DATA_W-1:0]  val_q;
  logic [oist_pkg::INDEX_W-1:0] idx_q;
  logic [CW-1:0]                cnt;
  logic [CW-1:0]                cnt_next;
  logic [CW-1:0]                ptr;
  logic                         pend;
  logic [AW-1:0]                pend_addr;
  logic [oist_pkg::DATA_W-1:0]  rdata;

  logic [AW-1:0]                raddr;
  logic [AW-1:0]                waddr;
  logic [oist_pkg::DATA_W-1:0]  wdata;
  logic                         wen;
  logic                         idx_ok;

  always_comb begin
    if (cmd.append) begin
      cnt_next = cnt + CW'(1);
    end else if (cmd.remove) begin
      cnt_next = cnt - CW'(1);
    end else begin
      cnt_next = cnt;
    end
  end

  assign idx_ok = XW'(idx_q) < XW'(cnt);
  assign raddr  = cmd.rd_idx ? AW'(idx_q) : ptr[AW-1:0];
  assign wen    = cmd.append || (cmd.shift_wr && pend);
  assign waddr  = cmd.append ? cnt[AW-1:0] : (pend_addr - AW'(1));
  assign wdata  = cmd.append ? val_q : rdata;

  assign sts.op       = op_q;
  assign sts.hit      = pend && (rdata == val_q);
  assign sts.scan_end = !pend && (ptr >= cnt);
  assign sts.full     = cnt >= CW'(CAPACITY);

  // table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= opcode;
      val_q <= value;
      idx_q <= index;
    end
    if (cmd.step && ptr < cnt) begin
      pend_addr <= ptr[AW-1:0];
    end
    if (cmd.finish) begin
      found        <= cmd.found;
      changed      <= cmd.changed;
      full_drop    <= cmd.drop;
      read_value   <= (cmd.rd && idx_ok) ? rdata : '0;
      read_invalid <= cmd.rd && !idx_ok;
      count        <= oist_pkg::COUNT_W'(cnt_next);
      empty_res    <= (cnt_next == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      ptr  <= '0;
      pend <= 1'b0;
      done <= 1'b0;
    end else begin
      cnt  <= cnt_next;
      done <= cmd.finish;
      if (cmd.load) begin
        ptr  <= '0;
        pend <= 1'b0;
      end else if (cmd.goto_shift) begin
        ptr  <= CW'(pend_addr) + CW'(1);
        pend <= 1'b0;
      end else if (cmd.step) begin
        if (ptr < cnt) begin
          ptr  <= ptr + CW'(1);
          pend <= 1'b1;
        end else begin
          pend <= 1'b0;
        end
      end
    end
  end

endmodule

### hw/rtl/oist_ctrl.sv
module oist_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  oist_pkg::sts_t sts,
  output logic           busy,
  output oist_pkg::cmd_t cmd
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_DECODE = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_SHIFT  = 5'b01000,
    ST_RDDATA = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  assign busy = (state != ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (sts.op)
          oist_pkg::OP_INSERT, oist_pkg::OP_DELETE: begin
            state_next = ST_SCAN;
          end
          oist_pkg::OP_READ: begin
            cmd.rd_idx = 1'b1;
            state_next = ST_RDDATA;
          end
          default: begin
            cmd.finish = 1'b1;
            state_next = ST_IDLE;
          end
        endcase
      end
      ST_SCAN: begin
        if (sts.hit) begin
          if (sts.op == oist_pkg::OP_DELETE) begin
            cmd.goto_shift = 1'b1;
            state_next     = ST_SHIFT;
          end else begin
            cmd.finish = 1'b1;
            cmd.found  = 1'b1;
            state_next = ST_IDLE;
          end
        end else if (sts.scan_end) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
          if (sts.op == oist_pkg::OP_INSERT) begin
            if (sts.full) begin
              cmd.drop = 1'b1;
            end else begin
              cmd.append  = 1'b1;
              cmd.changed = 1'b1;
            end
          end
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_SHIFT: begin
        if (sts.scan_end) begin
          cmd.remove  = 1'b1;
          cmd.finish  = 1'b1;
          cmd.found   = 1'b1;
          cmd.changed = 1'b1;
          state_next  = ST_IDLE;
        end else begin
          cmd.step     = 1'b1;
          cmd.shift_wr = 1'b1;
        end
      end
      ST_RDDATA: begin
        cmd.finish = 1'b1;
        cmd.rd     = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### hw/rtl/ordered_integer_set_table_core.sv
// One transaction at a time: busy stays high until its result is registered;
// the table scan and shift move one word per cycle.
// Reset (synchronous, rst high): count cleared, table contents left as they are.
// Results appear for one cycle with done; the receiver cannot stall.
module ordered_integer_set_table_core #(
  parameter int CAPACITY = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // command channel
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           opcode,
  input  logic signed [oist_pkg::DATA_W-1:0]   value,
  input  logic [oist_pkg::INDEX_W-1:0]         index,
  // result channel, one cycle per transaction
  output logic                                 done,
  output logic                                 found,
  output logic                                 changed,
  output logic                                 full_drop,
  output logic signed [oist_pkg::DATA_W-1:0]   read_value,
  output logic                                 read_invalid,
  output logic [oist_pkg::COUNT_W-1:0]         count,
  output logic                                 empty_res
);

  // Controller sequences each transaction:
  //   insert/delete: pipelined scan, one table read per cycle, compare on
  //   the returned word; insert appends at the end on a miss, unless full.
  //   delete on a hit: rewind to just past the hit and copy each later word
  //   one place down, one per cycle, then drop the count.
  //   read: one table read at index; the returned word goes to the result registers.
  oist_pkg::cmd_t cmd;
  oist_pkg::sts_t sts;

  oist_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Datapath: table memory, element count, scan pointer and result registers.
  oist_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .opcode       (opcode),
    .value        (value),
    .index        (index),
    .done         (done),
    .found        (found),
    .changed      (changed),
    .full_drop    (full_drop),
    .read_value   (read_value),
    .read_invalid (read_invalid),
    .count        (count),
    .empty_res    (empty_res)
  );

endmodule

### tb/testbench.sv
module testbench;
  localparam int         DATA_W    = oist_pkg::DATA_W;
  localparam int         INDEX_W   = oist_pkg::INDEX_W;
  localparam int         COUNT_W   = oist_pkg::COUNT_W;
  localparam logic [1:0] OP_INSERT = oist_pkg::OP_INSERT;
  localparam logic [1:0] OP_DELETE = oist_pkg::OP_DELETE;
  localparam logic [1:0] OP_READ   = oist_pkg::OP_READ;

  localparam int TABLE_DEPTH = 64;
  localparam int N_RANDOM    = 950;
  localparam int POOL_SIZE   = 80;
  // Worst transaction is a delete that hits in a full table:
  // scan to the hit plus shift. Settle window after the last one.
  localparam int SETTLE_CYCLES = 4 * TABLE_DEPTH + 40;
  // Opcode 3 is not named by the package; the block treats it as a no-op.
  localparam logic [1:0] OP_NOP = 2'd3;

  typedef struct packed {
    logic [1:0]                opcode;
    logic signed [DATA_W-1:0]  value;
    logic [INDEX_W-1:0]        index;
  } set_cmd_t;

  // One queued transaction plus sender timing: idle cycles before it goes out,
  // and whether the sender first waits for every outstanding result.
  typedef struct {
    set_cmd_t cmd;
    int       gap;
    bit       drain;
  } queued_cmd_t;

  typedef struct packed {
    logic                      found;
    logic                      changed;
    logic                      full_drop;
    logic signed [DATA_W-1:0]  read_value;
    logic                      read_invalid;
    logic [COUNT_W-1:0]        count;
    logic                      empty_res;
  } set_result_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       start = 1'b0;
  logic [1:0]                 opcode = OP_NOP;
  logic signed [DATA_W-1:0]   value = '0;
  logic [INDEX_W-1:0]         index = '0;
  logic                       busy;
  logic                       done;
  logic                       found;
  logic                       changed;
  logic                       full_drop;
  logic signed [DATA_W-1:0]   read_value;
  logic                       read_invalid;
  logic [COUNT_W-1:0]         count;
  logic                       empty_res;

  ordered_integer_set_table_core #(
    .CAPACITY(TABLE_DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .opcode(opcode),
    .value(value),
    .index(index),
    .done(done),
    .found(found),
    .changed(changed),
    .full_drop(full_drop),
    .read_value(read_value),
    .read_invalid(read_invalid),
    .count(count),
    .empty_res(empty_res)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow copy of the set: words kept in insertion order, valid below
  // shadow_size. Updated once per accepted transaction, in acceptance order.
  // ---------------------------------------------------------------------------
  logic signed [DATA_W-1:0] shadow_words [TABLE_DEPTH];
  int                       shadow_size = 0;

  function automatic set_result_t predict_set_op(set_cmd_t c);
    set_result_t r;
    int          hit_at;
    r = '0;
    hit_at = -1;
    for (int j = 0; j < shadow_size; j++) begin
      if (hit_at < 0 && shadow_words[j] == c.value) hit_at = j;
    end
    case (c.opcode)
      OP_INSERT: begin
        if (hit_at >= 0) begin
          r.found = 1'b1;
        end else if (shadow_size >= TABLE_DEPTH) begin
          r.full_drop = 1'b1;           // new value, no room: refused
        end else begin
          shadow_words[shadow_size] = c.value;
          shadow_size++;
          r.changed = 1'b1;
        end
      end
      OP_DELETE: begin
        if (hit_at >= 0) begin
          r.found   = 1'b1;
          r.changed = 1'b1;
          // close the hole: later entries slide down one place
          for (int k = hit_at; k + 1 < shadow_size; k++) shadow_words[k] = shadow_words[k + 1];
          shadow_size--;
        end
      end
      OP_READ: begin
        if (int'(c.index) < shadow_size) r.read_value = shadow_words[c.index];
        else r.read_invalid = 1'b1;
      end
      default: ;                        // no-op: flags stay zero
    endcase
    r.count     = COUNT_W'(shadow_size);
    r.empty_res = (shadow_size == 0);
    return r;
  endfunction

  queued_cmd_t command_q [$];
  set_result_t expected_results [$];
  int          transactions_sent = 0;
  int          results_seen = 0;      // NBA only, so the driver sees a stable value
  int          mismatch_total = 0;
  int          ops_by_code [4] = '{0, 0, 0, 0};
  int          drops_seen = 0;
  int          invalid_reads_seen = 0;
  int          full_table_seen = 0;
  int          empty_table_seen = 0;

  // ---------------------------------------------------------------------------
  // Driver: presents the head of command_q, holds it until start && !busy.
  // start is assigned once per edge, so back-to-back transactions keep it high.
  // ---------------------------------------------------------------------------
  int  hold_left = 0;
  bit  hold_armed = 1'b0;

  always @(posedge clk) begin
    set_cmd_t    accepted;
    queued_cmd_t nxt;
    bit          launch;
    if (rst) begin
      start      <= 1'b0;
      hold_armed = 1'b0;
    end else begin
      if (start && !busy) begin
        accepted = '{opcode: opcode, value: value, index: index};
        expected_results.push_back(predict_set_op(accepted));
        transactions_sent++;
        ops_by_code[opcode]++;
      end
      if (!(start && busy)) begin
        launch = 1'b0;
        if (command_q.size() != 0) begin
          if (!hold_armed) begin
            hold_left  = command_q[0].gap;
            hold_armed = 1'b1;
          end
          if (hold_left > 0) begin
            hold_left--;
          end else if (!command_q[0].drain || transactions_sent == results_seen) begin
            nxt = command_q.pop_front();
            opcode     <= nxt.cmd.opcode;
            value      <= nxt.cmd.value;
            index      <= nxt.cmd.index;
            launch     = 1'b1;
            hold_armed = 1'b0;
          end
        end
        start <= launch;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: done is a one-cycle strobe that cannot be held off, so every
  // sampled done is a result transaction. Compare against the oldest prediction.
  // ---------------------------------------------------------------------------
  task automatic compare_field(input string fname, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
      mismatch_total++;
    end
  endtask

  always @(posedge clk) begin
    set_result_t want;
    if (!rst && done) begin
      results_seen <= results_seen + 1;
      if (full_drop === 1'b1) drops_seen++;
      if (read_invalid === 1'b1) invalid_reads_seen++;
      if (count === COUNT_W'(TABLE_DEPTH)) full_table_seen++;
      if (empty_res === 1'b1) empty_table_seen++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual count=%0d read_value=%0h",
                 $time, count, read_value);
        mismatch_total++;
      end else begin
        want = expected_results.pop_front();
        compare_field("found", DATA_W'(want.found), DATA_W'(found));
        compare_field("changed", DATA_W'(want.changed), DATA_W'(changed));
        compare_field("full_drop", DATA_W'(want.full_drop), DATA_W'(full_drop));
        compare_field("read_value", want.read_value, read_value);
        compare_field("read_invalid", DATA_W'(want.read_invalid), DATA_W'(read_invalid));
        compare_field("count", DATA_W'(want.count), DATA_W'(count));
        compare_field("empty_res", DATA_W'(want.empty_res), DATA_W'(empty_res));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  logic signed [DATA_W-1:0] value_pool [POOL_SIZE];

  task automatic add_cmd(input logic [1:0] op, input logic signed [DATA_W-1:0] v,
                         input logic [INDEX_W-1:0] idx, input int gap, input bit drain);
    queued_cmd_t q;
    q.cmd   = '{opcode: op, value: v, index: idx};
    q.gap   = gap;
    q.drain = drain;
    command_q.push_back(q);
  endtask

  localparam logic signed [DATA_W-1:0] INT_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7fff_ffff;

  initial begin
    int  made;
    int  phase_kind;
    int  phase_len;
    bit  no_idle;
    int  roll;
    int  gap;
    logic [1:0]                op;
    logic signed [DATA_W-1:0]  v;

    // Pool of recurring values so inserts collide and the table can fill.
    value_pool[0] = INT_MIN;
    value_pool[1] = INT_MAX;
    value_pool[2] = 0;
    value_pool[3] = -1;
    value_pool[4] = 1;
    for (int p = 5; p < POOL_SIZE; p++) value_pool[p] = $urandom;

    // Directed: empty-table corners, extremes, duplicate insert, reads at and
    // past the count, deletes of first / last / middle / absent, no-ops.
    add_cmd(OP_READ,   0,       6'd0,  $urandom_range(0, 17), 1'b0); // read on empty
    add_cmd(OP_DELETE, 5,       6'd0,  0, 1'b0);                     // delete on empty
    add_cmd(OP_NOP,    0,       6'd0,  0, 1'b0);
    add_cmd(OP_INSERT, INT_MIN, 6'd0,  0, 1'b0);
    add_cmd(OP_INSERT, INT_MAX, 6'd63, $urandom_range(0, 17), 1'b0);
    add_cmd(OP_INSERT, 0,       6'd0,  0, 1'b0);
    add_cmd(OP_INSERT, -1,      6'd0,  0, 1'b0);
    add_cmd(OP_INSERT, INT_MAX, 6'd0,  0, 1'b0);                     // already present
    add_cmd(OP_READ,   0,       6'd0,  $urandom_range(0, 17), 1'b0);
    add_cmd(OP_READ,   -1,      6'd3,  0, 1'b0);                     // last valid slot
    add_cmd(OP_READ,   0,       6'd4,  0, 1'b0);                     // at the count
    add_cmd(OP_READ,   0,       6'd63, 0, 1'b0);
    add_cmd(OP_DELETE, INT_MIN, 6'd0,  5, 1'b1);                     // first, full shift
    add_cmd(OP_READ,   0,       6'd0,  0, 1'b0);
    add_cmd(OP_DELETE, -1,      6'd0,  $urandom_range(0, 17), 1'b0); // last, no shift
    add_cmd(OP_DELETE, 12345,   6'd0,  0, 1'b0);                     // absent
    add_cmd(OP_INSERT, 1,       6'd0,  0, 1'b0);
    add_cmd(OP_DELETE, 0,       6'd0,  0, 1'b0);                     // middle
    add_cmd(OP_READ,   0,       6'd1,  0, 1'b0);
    add_cmd(OP_NOP,    -1,      6'd63, $urandom_range(0, 17), 1'b0);
    add_cmd(OP_DELETE, 1,       6'd0,  0, 1'b0);
    add_cmd(OP_DELETE, INT_MAX, 6'd0,  0, 1'b0);                     // back to empty
    add_cmd(OP_READ,   0,       6'd0,  0, 1'b0);

    // Random: phases biased toward filling (reaches capacity and refusals),
    // draining (walks the count back to zero) or a mix. Some phases run with
    // no sender idling, some start by waiting for the block to go quiet.
    made = 0;
    while (made < N_RANDOM) begin
      phase_kind = $urandom_range(0, 3);
      phase_len  = $urandom_range(40, 160);
      no_idle    = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < phase_len && made < N_RANDOM; n++) begin
        roll = $urandom_range(0, 99);
        case (phase_kind)
          0, 1:    op = (roll < 70) ? OP_INSERT : (roll < 80) ? OP_DELETE :
                        (roll < 97) ? OP_READ : OP_NOP;
          2:       op = (roll < 15) ? OP_INSERT : (roll < 80) ? OP_DELETE :
                        (roll < 97) ? OP_READ : OP_NOP;
          default: op = (roll < 35) ? OP_INSERT : (roll < 65) ? OP_DELETE :
                        (roll < 95) ? OP_READ : OP_NOP;
        endcase
        v   = ($urandom_range(0, 4) != 0) ? value_pool[$urandom_range(0, POOL_SIZE - 1)]
                                          : $urandom;
        gap = no_idle ? 0 : $urandom_range(0, 17);
        add_cmd(op, v, INDEX_W'($urandom_range(0, 63)), gap,
                (n == 0) && ($urandom_range(0, 2) == 0));
        made++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Reset, end of run and verdict
  // ---------------------------------------------------------------------------
  initial begin
    int leftover;
    rst = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (command_q.size() != 0 || start || transactions_sent != results_seen)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    leftover = expected_results.size();
    if (leftover != 0)
      $display("%0t: %0d expected results never arrived", $time, leftover);
    $display("ran %0d transactions: %0d inserts, %0d deletes, %0d reads, %0d no-ops",
             transactions_sent, ops_by_code[OP_INSERT], ops_by_code[OP_DELETE],
             ops_by_code[OP_READ], ops_by_code[OP_NOP]);
    $display("saw %0d refused inserts, %0d reads past the count, %0d full and %0d empty results",
             drops_seen, invalid_reads_seen, full_table_seen, empty_table_seen);
    if (mismatch_total == 0 && leftover == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #3000000;
    $display("%0t: timeout", $time);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
